/* hdl/rds_pkg.sv */
// Shared types, constants and SHA-256 helpers for the record deframer.
package rds_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  localparam logic [2:0] StComplete = 3'd0;
  localparam logic [2:0] StEnd      = 3'd1;
  localparam logic [2:0] StBadSize  = 3'd2;
  localparam logic [2:0] StPartLen  = 3'd3;
  localparam logic [2:0] StPartRec  = 3'd4;

  localparam logic OpData = 1'b0;
  localparam logic OpEnd  = 1'b1;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_PAY,
    PH_DIG,
    PH_DROP
  } phase_e;

  typedef enum logic [2:0] {
    CMD_PASS,
    CMD_DIG,
    CMD_CHECK,
    CMD_STATUS,
    CMD_START
  } cmd_e;

  typedef enum logic [0:0] {
    BS_RUN,
    BS_WAIT
  } back_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PAD,
    CS_ROUND,
    CS_ADD
  } core_state_e;

  typedef struct packed {
    cmd_e        op;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  status;
    logic [31:0] length;
  } cmd_t;

  typedef struct packed {
    logic       start;
    logic       feed;
    logic       finish;
    logic [7:0] data;
  } core_req_t;

  typedef struct packed {
    logic         idle;
    logic [255:0] digest;
  } core_rsp_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* hdl/rds_front.sv */
// Front end: length parsing, size check and classification of each beat into a command.
module rds_front #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [7:0]         data_byte_i,
  input  logic [31:0]        max_len_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rds_pkg::cmd_t      q_cmd_o
);
  import rds_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [31:0]            rec_q, rec_d;
  logic [31:0]            len_new;
  logic                   take, bad, last;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && !q_full_i;

  always_comb begin
    len_new = rec_q | (32'(data_byte_i) << {cnt_q[1:0], 3'b000});
    bad     = (len_new == 32'd0) || (len_new > max_len_i) ||
              ((64'(len_new) >> LENGTH_BITS) != 64'd0);
    last    = (33'(cnt_q) + 33'd1) == 33'(rec_q);
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rec_d   = rec_q;
    if (take) begin
      if (opcode_i == OpEnd) begin
        phase_d = PH_LEN;
        cnt_d   = '0;
        rec_d   = '0;
      end else begin
        case (phase_q)
          PH_LEN: begin
            rec_d = len_new;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q[1:0] == 2'd3) begin
              cnt_d   = '0;
              phase_d = bad ? PH_DROP : PH_PAY;
            end
          end
          PH_PAY: begin
            if (last) begin
              phase_d = PH_DIG;
              cnt_d   = '0;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          PH_DIG: begin
            if (cnt_q[4:0] == 5'd31) begin
              phase_d = PH_LEN;
              cnt_d   = '0;
              rec_d   = '0;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // command to the queue
  always_comb begin
    q_push_o = 1'b0;
    q_cmd_o  = '{op: CMD_STATUS, data: data_byte_i, last: 1'b0, status: StEnd,
                 length: rec_q};
    if (take) begin
      if (opcode_i == OpEnd) begin
        case (phase_q)
          PH_DROP: q_push_o = 1'b0;
          PH_LEN: begin
            q_push_o       = 1'b1;
            q_cmd_o.length = '0;
            q_cmd_o.status = (cnt_q == '0) ? StEnd : StPartLen;
          end
          default: begin
            q_push_o       = 1'b1;
            q_cmd_o.status = StPartRec;
          end
        endcase
      end else begin
        case (phase_q)
          PH_LEN: begin
            if (cnt_q[1:0] == 2'd3) begin
              q_push_o       = 1'b1;
              q_cmd_o.length = len_new;
              if (bad) begin
                q_cmd_o.status = StBadSize;
              end else begin
                q_cmd_o.op = CMD_START;
              end
            end
          end
          PH_PAY: begin
            q_push_o     = 1'b1;
            q_cmd_o.op   = CMD_PASS;
            q_cmd_o.last = last;
          end
          PH_DIG: begin
            q_push_o   = 1'b1;
            q_cmd_o.op = (cnt_q[4:0] == 5'd31) ? CMD_CHECK : CMD_DIG;
          end
          default: q_push_o = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      cnt_q   <= '0;
      rec_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      rec_q   <= rec_d;
    end
  end

endmodule

/* hdl/rds_fifo.sv */
// Short command queue between the front end and the back end.
module rds_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rds_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output rds_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import rds_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoPtrW+1)'(do_push) - (FifoPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

endmodule

/* hdl/rds_sha_core.sv */
// SHA-256 engine: byte loading, padding sequencer and one compression round a cycle.
module rds_sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rds_pkg::core_req_t req_i,
  output rds_pkg::core_rsp_t rsp_o
);
  import rds_pkg::*;

  core_state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [34:0] bits_q;
  logic [5:0]  rnd_q;
  logic        pad_q, first_q, lenph_q;
  logic [2:0]  lcnt_q;
  logic [63:0] len_q;
  logic [5:0]  pos;
  logic        shift_en;
  logic [7:0]  byte_in;
  logic [31:0] t1, t2, s0, s1, w_new;

  assign pos = bits_q[8:3];

  always_comb begin
    shift_en = ((state_q == CS_IDLE) && req_i.feed) || (state_q == CS_PAD);
    if (state_q != CS_PAD)                byte_in = req_i.data;
    else if (first_q)                     byte_in = 8'h80;
    else if (lenph_q || (pos == 6'd56))   byte_in = len_q[63:56];
    else                                  byte_in = 8'h00;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (req_i.feed && (pos == 6'd63)) state_d = CS_ROUND;
        else if (req_i.finish)            state_d = CS_PAD;
      end
      CS_PAD:   if (pos == 6'd63) state_d = CS_ROUND;
      CS_ROUND: if (rnd_q == 6'd63) state_d = CS_ADD;
      CS_ADD:   state_d = pad_q ? CS_PAD : CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w_q[0];
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      bits_q  <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      lenph_q <= 1'b0;
      lcnt_q  <= '0;
      rnd_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      state_q <= state_d;
      if ((state_q == CS_IDLE) && req_i.start) begin
        bits_q <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      end
      if (shift_en) bits_q <= bits_q + 35'd8;
      if ((state_q == CS_IDLE) && !req_i.feed && req_i.finish) begin
        pad_q   <= 1'b1;
        first_q <= 1'b1;
      end
      if (state_q == CS_PAD) begin
        first_q <= 1'b0;
        if (!first_q && (lenph_q || (pos == 6'd56))) begin
          lenph_q <= 1'b1;
          lcnt_q  <= lcnt_q + 1'b1;
          if (lcnt_q == 3'd7) begin
            lenph_q <= 1'b0;
            pad_q   <= 1'b0;
          end
        end
      end
      if (shift_en && (pos == 6'd63)) rnd_q <= '0;
      else if (state_q == CS_ROUND)  rnd_q <= rnd_q + 1'b1;
      if (state_q == CS_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  // message window, working variables and length latch
  always_ff @(posedge clk_i) begin
    if ((state_q == CS_IDLE) && !req_i.feed && req_i.finish) len_q <= 64'(bits_q);
    else if ((state_q == CS_PAD) && !first_q && (lenph_q || (pos == 6'd56)))
      len_q <= {len_q[55:0], 8'h00};
    if (shift_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[15] <= {w_q[15][23:0], byte_in};
      if (pos == 6'd63) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end else if (state_q == CS_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign rsp_o.idle   = (state_q == CS_IDLE);
  assign rsp_o.digest = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};

endmodule

/* hdl/rds_back.sv */
// Back end: executes queued commands, drives the hash engine and the output register.
module rds_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rds_pkg::cmd_t      head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output rds_pkg::core_req_t core_req_o,
  input  rds_pkg::core_rsp_t core_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_kind_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [2:0]         out_status_o,
  output logic [31:0]        out_length_o,
  output logic               out_ok_o
);
  import rds_pkg::*;

  back_state_e  state_q, state_d;
  logic         ov_q;
  logic         kind_q, last_q, ok_q;
  logic [7:0]   byte_q;
  logic [2:0]   st_q;
  logic [31:0]  len_q, wlen_q;
  logic [255:0] dig_q;
  logic         free, load, shift_dig, run;

  assign free = !ov_q || out_ready_i;
  assign run  = (state_q == BS_RUN) && !empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_RUN:  if (run && (head_i.op == CMD_CHECK) && core_rsp_i.idle) state_d = BS_WAIT;
      BS_WAIT: if (core_rsp_i.idle && free) state_d = BS_RUN;
      default: state_d = BS_RUN;
    endcase
  end

  always_comb begin
    pop_o      = 1'b0;
    load       = 1'b0;
    shift_dig  = 1'b0;
    core_req_o = '{start: 1'b0, feed: 1'b0, finish: 1'b0, data: head_i.data};
    case (state_q)
      BS_RUN: begin
        if (run) begin
          case (head_i.op)
            CMD_PASS: if (core_rsp_i.idle && free) begin
              pop_o           = 1'b1;
              load            = 1'b1;
              core_req_o.feed = 1'b1;
            end
            CMD_DIG: begin
              pop_o     = 1'b1;
              shift_dig = 1'b1;
            end
            CMD_CHECK: if (core_rsp_i.idle) begin
              pop_o             = 1'b1;
              shift_dig         = 1'b1;
              core_req_o.finish = 1'b1;
            end
            CMD_STATUS: if (free) begin
              pop_o = 1'b1;
              load  = 1'b1;
            end
            CMD_START: if (core_rsp_i.idle) begin
              pop_o            = 1'b1;
              core_req_o.start = 1'b1;
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      BS_WAIT: load = core_rsp_i.idle && free;
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_RUN;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load)             ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_dig) dig_q <= {dig_q[247:0], head_i.data};
    if (run && (head_i.op == CMD_CHECK)) wlen_q <= head_i.length;
    if (load) begin
      if (state_q == BS_WAIT) begin
        kind_q <= KindStatus;
        byte_q <= 8'h00;
        last_q <= 1'b0;
        st_q   <= StComplete;
        len_q  <= wlen_q;
        ok_q   <= (dig_q == core_rsp_i.digest);
      end else if (head_i.op == CMD_PASS) begin
        kind_q <= KindPayload;
        byte_q <= head_i.data;
        last_q <= head_i.last;
        st_q   <= StComplete;
        len_q  <= head_i.length;
        ok_q   <= 1'b0;
      end else begin
        kind_q <= KindStatus;
        byte_q <= 8'h00;
        last_q <= 1'b0;
        st_q   <= head_i.status;
        len_q  <= head_i.length;
        ok_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_kind_o   = kind_q;
  assign out_byte_o   = byte_q;
  assign out_last_o   = last_q;
  assign out_status_o = st_q;
  assign out_length_o = len_q;
  assign out_ok_o     = ok_q;

endmodule

/* hdl/record_deframer_sha256_check.sv */
// Top level: length-prefixed record deframer with SHA-256 digest check.
//
//   port group  dir   tdata / data                          tuser / tlast
//   s_axis      in    [7:0] data_byte                       tuser: opcode
//   m_axis      out   [7:0] byte [10:8] status              tuser: kind
//                     [42:11] length [43] checksum_valid    tlast: payload_last
//   apb         in    0x0 max_payload_bytes                 -
//
// Every 64th hashed byte starts a compression (one SHA-256 round per cycle
// plus the final add). Closing a record pads byte by byte and then runs one
// or two compressions.
// Reset clears the parser, the queue and the hash state; no clearing pass.
// Input is stalled only when the four-entry command queue is full.
module record_deframer_sha256_check #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                      // [42:11] payload_length, [43] checksum_valid
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rds_pkg::*;

  logic [31:0] max_q;
  logic        push, pop, empty, full;
  cmd_t        push_cmd, head;
  core_req_t   core_req;
  core_rsp_t   core_rsp;
  logic [2:0]  st;
  logic [31:0] len;
  logic        ok;
  logic [7:0]  pbyte;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? max_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 32'd1048576;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      max_q <= pwdata;
    end
  end

  rds_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .max_len_i   (max_q),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_cmd_o     (push_cmd)
  );

  rds_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty),
    .full_o     (full)
  );

  rds_sha_core u_sha (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (core_req),
    .rsp_o  (core_rsp)
  );

  rds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .core_req_o   (core_req),
    .core_rsp_i   (core_rsp),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_byte_o   (pbyte),
    .out_last_o   (m_axis_tlast),
    .out_status_o (st),
    .out_length_o (len),
    .out_ok_o     (ok)
  );

  assign m_axis_tdata = {4'b0000, ok, len, st, pbyte};

endmodule

/* test/record_deframer_sha256_check_tb.sv */
// Self-checking testbench for the record deframer with SHA-256 digest check.
module record_deframer_sha256_check_tb;
  import rds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned RandomItems = 1600;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [255:0] SHA_IV = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        last;
    logic [2:0]  status;
    logic [31:0] length;
    logic        ok;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  item_t       stream_items[$];
  beat_t       expected_beats[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned beats_in = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          long_stall_done = 1'b0;

  // predictor state
  phase_e      ph = PH_LEN;
  logic [31:0] cnt = '0;
  logic [31:0] rec_len = '0;
  logic [31:0] max_bytes = 32'd1048576;
  logic [255:0] hw = SHA_IV;
  logic [511:0] blk = '0;
  logic [34:0] bit_cnt = '0;
  logic [255:0] dig = '0;

  record_deframer_sha256_check u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(input logic [255:0] h, input logic [511:0] m);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, k, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = m[511-32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    {a, b, c, d, e, f, g, k} = h;
    for (int i = 0; i < 64; i++) begin
      t1 = k + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      k = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    return {h[255:224] + a, h[223:192] + b, h[191:160] + c, h[159:128] + d,
            h[127:96] + e, h[95:64] + f, h[63:32] + g, h[31:0] + k};
  endfunction

  // padding and length words, then the last one or two compressions
  function automatic logic [255:0] sha_finish(input logic [255:0] h, input logic [511:0] m,
                                              input logic [34:0] nbits);
    int n;
    logic [63:0] len64;
    n = int'(nbits[8:3]);
    len64 = 64'(nbits);
    m[511-8*n -: 8] = 8'h80;
    n++;
    if (n > 56) begin
      for (; n < 64; n++) m[511-8*n -: 8] = 8'h00;
      h = sha_compress(h, m);
      n = 0;
    end
    for (; n < 56; n++) m[511-8*n -: 8] = 8'h00;
    m[63:0] = len64;
    return sha_compress(h, m);
  endfunction

  function automatic logic [255:0] sha_of(input logic [7:0] bytes[$]);
    logic [255:0] h;
    logic [511:0] m;
    logic [34:0] nb;
    h = SHA_IV;
    m = '0;
    nb = '0;
    foreach (bytes[i]) begin
      m[511-8*int'(nb[8:3]) -: 8] = bytes[i];
      nb = nb + 35'd8;
      if (nb[8:3] == 6'd0) h = sha_compress(h, m);
    end
    return sha_finish(h, m, nb);
  endfunction

  task automatic deframe_step(input logic op, input logic [7:0] b);
    beat_t r;
    r = '0;
    if (op == OpEnd) begin
      if (ph != PH_DROP) begin
        r.kind = KindStatus;
        if (ph == PH_LEN) begin
          r.status = (cnt == 0) ? StEnd : StPartLen;
        end else begin
          r.status = StPartRec;
          r.length = rec_len;
        end
        expected_beats.insert(expected_beats.size(), r);
      end
      ph = PH_LEN; cnt = '0; rec_len = '0;
      return;
    end
    case (ph)
      PH_LEN: begin
        rec_len[8*int'(cnt[1:0]) +: 8] = b;
        cnt++;
        if (cnt == 4) begin
          cnt = '0;
          if (rec_len == 0 || rec_len > max_bytes) begin
            ph = PH_DROP;
            r.kind = KindStatus; r.status = StBadSize; r.length = rec_len;
            expected_beats.insert(expected_beats.size(), r);
          end else begin
            ph = PH_PAY; hw = SHA_IV; bit_cnt = '0;
          end
        end
      end
      PH_PAY: begin
        r.kind = KindPayload; r.data = b; r.length = rec_len;
        r.last = (cnt + 32'd1 == rec_len);
        blk[511-8*int'(bit_cnt[8:3]) -: 8] = b;
        bit_cnt = bit_cnt + 35'd8;
        if (bit_cnt[8:3] == 6'd0) hw = sha_compress(hw, blk);
        expected_beats.insert(expected_beats.size(), r);
        if (r.last) begin
          ph = PH_DIG; cnt = '0;
        end else begin
          cnt++;
        end
      end
      PH_DIG: begin
        dig[255-8*int'(cnt[4:0]) -: 8] = b;
        cnt++;
        if (cnt == 32) begin
          r.kind = KindStatus; r.status = StComplete; r.length = rec_len;
          r.ok = (sha_finish(hw, blk, bit_cnt) == dig);
          expected_beats.insert(expected_beats.size(), r);
          ph = PH_LEN; cnt = '0; rec_len = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      deframe_step(s_axis_tuser, s_axis_tdata);
      void'(stream_items.pop_front());
      beats_in++;
      gap_left = (beats_in >= 600 && beats_in < 800) ? 0 : pick_gap();
    end
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // hold the offered beat
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid <= 1'b0;
    end else if (stream_items.size() > 0) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= stream_items[0].op;
      s_axis_tdata <= stream_items[0].data;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // receiver back-pressure, with one long hold-off while input keeps coming
  always @(posedge clk_i) begin
    if (!long_stall_done && beats_in >= 300) begin
      long_stall_done = 1'b1;
      stall_left = 500;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (beats_in >= 600 && beats_in < 800) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50 && !m_axis_tready);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected beat tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tuser !== want.kind)
          report($sformatf("kind %b, want %b", m_axis_tuser, want.kind));
        if (m_axis_tdata[7:0] !== want.data)
          report($sformatf("byte %h, want %h", m_axis_tdata[7:0], want.data));
        if (m_axis_tlast !== want.last)
          report($sformatf("last %b, want %b", m_axis_tlast, want.last));
        if (m_axis_tdata[10:8] !== want.status)
          report($sformatf("status %0d, want %0d", m_axis_tdata[10:8], want.status));
        if (m_axis_tdata[42:11] !== want.length)
          report($sformatf("length %h, want %h", m_axis_tdata[42:11], want.length));
        if (m_axis_tdata[43] !== want.ok)
          report($sformatf("checksum_valid %b, want %b", m_axis_tdata[43], want.ok));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d beats still expected", expected_beats.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    stream_items.insert(stream_items.size(), '{op: OpData, data: b});
  endtask

  task automatic put_end();
    stream_items.insert(stream_items.size(), '{op: OpEnd, data: 8'($urandom)});
  endtask

  task automatic put_len(input logic [31:0] l);
    for (int i = 0; i < 4; i++) put_byte(l[8*i +: 8]);
  endtask

  // mode 0 good digest, 1 corrupted digest, 2 cut short then end
  task automatic put_record(input logic [31:0] l, input int mode);
    logic [7:0] pay[$];
    logic [255:0] d;
    int stop;
    for (int i = 0; i < int'(l); i++) pay.insert(pay.size(), 8'($urandom));
    d = sha_of(pay);
    if (mode == 1) d[$urandom_range(0, 255)] ^= 1'b1;
    stop = (mode == 2) ? $urandom_range(0, int'(l) + 31) : int'(l) + 32;
    put_len(l);
    for (int i = 0; i < stop; i++) put_byte(i < int'(l) ? pay[i] : d[255-8*(i-int'(l)) -: 8]);
    if (mode == 2) put_end();
  endtask

  function automatic logic [31:0] pick_len();
    logic [31:0] l;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) l = 32'($urandom_range(0, 5) == 0 ? 55 : 56 + 8 * $urandom_range(0, 8));
    else if (r < 25) l = 32'($urandom_range(119, 129));
    else if (r < 35) l = max_bytes;
    else l = 32'($urandom_range(1, 40));
    if (l > max_bytes || l > 200) l = 32'($urandom_range(1, max_bytes < 40 ? int'(max_bytes) : 40));
    return l;
  endfunction

  task automatic apb_write(input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    max_bytes = v;
  endtask

  task automatic drain();
    while (stream_items.size() != 0 || s_axis_tvalid || expected_beats.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] settings [6];
    logic [31:0] l;
    int unsigned r;
    settings = '{32'd1, 32'hFFFF_FFFF, 32'd64, 32'd1048576, 32'd0, 32'd200};
    settings[4] = 32'($urandom_range(2, 150));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: end at boundary, end inside length, zero and oversize length, cut payload
    put_end();
    put_byte(8'h00); put_byte(8'hFF); put_end();
    put_len(32'd0); put_byte(8'hA5); put_byte(8'h5A); put_end();
    put_len(32'hFFFF_FFFF); put_end();
    put_len(32'd3); put_byte(8'h00); put_byte(8'hFF); put_end();
    drain();
    apb_write(32'd1);
    put_len(32'd1); put_byte(8'h80); put_end();
    put_len(32'd2); put_end();
    drain();

    foreach (settings[s]) begin
      apb_write(settings[s]);
      while (stream_items.size() < RandomItems / 6) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          put_record(pick_len(), 0);
        end else if (r < 70) begin
          put_record(pick_len(), 1);
        end else if (r < 80) begin
          put_record(pick_len(), 2);
        end else if (r < 87) begin
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
          put_end();
        end else if (r < 95) begin
          if (max_bytes == 32'hFFFF_FFFF || $urandom_range(0, 3) == 0) l = '0;
          else l = max_bytes + 32'($urandom_range(1, 1000));
          if (l < max_bytes) l = '0;
          put_len(l);
          repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
          put_end();
        end else begin
          put_end();
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
